// File: design/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg: shared types and constants for the prime factorizer
// Widths, the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pf_pkg;

  // Width of the value to factor and of each factor
  localparam int VALUE_BITS   = 31;
  // Trial divisors stay below sqrt(2^VALUE_BITS) + 2
  localparam int DIV_BITS     = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS      = 2 * DIV_BITS;
  localparam int STEP_BITS    = $clog2(VALUE_BITS);
  // Results kept per input value
  localparam int RESULT_CAP   = 30;
  localparam int COUNT_BITS   = $clog2(RESULT_CAP + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [DIV_BITS-1:0]   divisor_t;
  typedef logic [SQ_BITS-1:0]    square_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam value_t   FIRST_PRIME = VALUE_BITS'(2);
  localparam divisor_t FIRST_ODD   = DIV_BITS'(3);
  localparam divisor_t DIV_STRIDE  = DIV_BITS'(2);
  localparam square_t  FIRST_SQ    = SQ_BITS'(9);
  // (d + 2)^2 - d^2 = 4d + 4
  localparam square_t  SQ_STEP     = SQ_BITS'(4);
  localparam count_t   CAP_COUNT   = COUNT_BITS'(RESULT_CAP);
  localparam count_t   CAP_LAST    = COUNT_BITS'(RESULT_CAP - 1);

  // Source of a newly found factor
  typedef enum logic [1:0] {
    FOUND_TWO   = 2'd0,
    FOUND_TRIAL = 2'd1,
    FOUND_REM   = 2'd2
  } pf_found_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic          load;       // take a new value, reset the run
    logic          halve;      // divide remaining by two
    logic          div_start;  // launch remaining / trial divisor
    logic          take_quot;  // remaining <= quotient
    logic          step_trial; // advance to the next odd divisor
    logic          found;      // record a factor, push the held one
    pf_found_sel_e found_sel;
    logic          flush;      // push the held factor as the last one
  } pf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic value_lt2;    // input value has no prime factors
    logic rem_even;
    logic rem_gt2;
    logic sq_gt_rem;    // trial divisor squared exceeds remaining
    logic div_busy;
    logic div_rem_zero;
    logic out_free;     // output register can take a transaction
  } pf_status_t;

endpackage

// File: design/pf_value_if.sv
// ----------------------------------------------------------------------------
// pf_value_if: input channel of the prime factorizer
// Valid/ready handshake carrying one value to factor.
// ----------------------------------------------------------------------------
interface pf_value_if;
  logic            valid;
  logic            ready;
  pf_pkg::value_t  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: design/pf_factor_if.sv
// ----------------------------------------------------------------------------
// pf_factor_if: output channel of the prime factorizer
// Valid/ready handshake carrying one prime factor and its last flag.
// ----------------------------------------------------------------------------
interface pf_factor_if;
  logic            valid;
  logic            ready;
  pf_pkg::value_t  factor;
  logic            last;

  modport source (output valid, output factor, output last, input ready);
  modport sink   (input valid, input factor, input last, output ready);
endinterface

// File: design/pf_div.sv
// ----------------------------------------------------------------------------
// pf_div: bit-serial restoring divider
// One quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module pf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pf_pkg::value_t      dividend_i,
  input  pf_pkg::divisor_t    divisor_i,
  output logic                busy_o,
  output pf_pkg::value_t      quot_o,
  output pf_pkg::divisor_t    rem_o
);

  logic                              busy_q, busy_d;
  logic [pf_pkg::STEP_BITS-1:0]      step_q, step_d;
  pf_pkg::value_t                    num_q, num_d;
  pf_pkg::divisor_t                  part_q, part_d;
  pf_pkg::divisor_t                  dsr_q, dsr_d;
  logic [pf_pkg::DIV_BITS:0]         trial_rem;
  logic                              fits;

  // Shift in the next dividend bit and try a subtraction
  assign trial_rem = {part_q, num_q[pf_pkg::VALUE_BITS-1]};
  assign fits      = trial_rem >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    num_d  = num_q;
    part_d = part_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = pf_pkg::STEP_BITS'(pf_pkg::VALUE_BITS - 1);
      num_d  = dividend_i;
      part_d = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[pf_pkg::VALUE_BITS-2:0], fits};
      if (fits) begin
        part_d = pf_pkg::DIV_BITS'(trial_rem - {1'b0, dsr_q});
      end else begin
        part_d = trial_rem[pf_pkg::DIV_BITS-1:0];
      end
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    num_q  <= num_d;
    part_q <= part_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quot_o = num_q;
  assign rem_o  = part_q;

endmodule

// File: design/pf_dp.sv
// ----------------------------------------------------------------------------
// pf_dp: prime factorizer datapath
// Remaining value, trial divisor and its square, held factor, output register.
// ----------------------------------------------------------------------------
module pf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pf_pkg::pf_cmd_t     cmd_i,
  output pf_pkg::pf_status_t  status_o,
  input  pf_pkg::value_t      value_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output pf_pkg::value_t      out_factor_o,
  output logic                out_last_o
);

  pf_pkg::value_t    rem_q, rem_d;
  pf_pkg::divisor_t  trial_q, trial_d;
  pf_pkg::square_t   sq_q, sq_d;
  pf_pkg::value_t    pend_q, pend_d;
  logic              pend_valid_q, pend_valid_d;
  pf_pkg::count_t    count_q, count_d;
  logic              out_valid_q, out_valid_d;
  pf_pkg::value_t    out_factor_q, out_factor_d;
  logic              out_last_q, out_last_d;

  pf_pkg::value_t    found_val;
  pf_pkg::value_t    div_dividend;
  pf_pkg::value_t    quot;
  pf_pkg::divisor_t  div_rem;
  logic              div_busy;
  logic              push;
  logic              push_keep;

  // Divider: a repeat division by the same divisor starts from the quotient
  assign div_dividend = cmd_i.take_quot ? quot : rem_q;

  pf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (trial_q),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (div_rem)
  );

  // Select the factor just found
  always_comb begin
    unique case (cmd_i.found_sel)
      pf_pkg::FOUND_TWO:   found_val = pf_pkg::FIRST_PRIME;
      pf_pkg::FOUND_TRIAL: found_val = pf_pkg::VALUE_BITS'(trial_q);
      pf_pkg::FOUND_REM:   found_val = rem_q;
      default:             found_val = rem_q;
    endcase
  end

  // Push the held factor on a new find or at the end; drop past the cap
  assign push      = (cmd_i.found && pend_valid_q) || cmd_i.flush;
  assign push_keep = push && (count_q < pf_pkg::CAP_COUNT);

  always_comb begin
    rem_d        = rem_q;
    trial_d      = trial_q;
    sq_d         = sq_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_factor_d = out_factor_q;
    out_last_d   = out_last_q;

    // Run setup
    if (cmd_i.load) begin
      rem_d        = value_i;
      trial_d      = pf_pkg::FIRST_ODD;
      sq_d         = pf_pkg::FIRST_SQ;
      pend_valid_d = 1'b0;
      count_d      = '0;
    end

    // Reduce remaining
    if (cmd_i.halve) begin
      rem_d = rem_q >> 1;
    end
    if (cmd_i.take_quot) begin
      rem_d = quot;
    end

    // Advance trial divisor and its square together
    if (cmd_i.step_trial) begin
      trial_d = trial_q + pf_pkg::DIV_STRIDE;
      sq_d    = sq_q + pf_pkg::SQ_BITS'({trial_q, 2'b00}) + pf_pkg::SQ_STEP;
    end

    // Hold the newest factor back so the final one can be marked
    if (cmd_i.found) begin
      pend_d       = found_val;
      pend_valid_d = 1'b1;
    end
    if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
    end

    // Output register
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (push_keep) begin
      out_valid_d  = 1'b1;
      out_factor_d = pend_q;
      out_last_d   = cmd_i.flush || (count_q == pf_pkg::CAP_LAST);
      count_d      = count_q + 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    trial_q      <= trial_d;
    sq_q         <= sq_d;
    pend_q       <= pend_d;
    out_factor_q <= out_factor_d;
    out_last_q   <= out_last_d;
  end

  // Status back to the controller
  assign status_o.value_lt2    = value_i < pf_pkg::FIRST_PRIME;
  assign status_o.rem_even     = !rem_q[0];
  assign status_o.rem_gt2      = rem_q > pf_pkg::FIRST_PRIME;
  assign status_o.sq_gt_rem    = sq_q > pf_pkg::SQ_BITS'(rem_q);
  assign status_o.div_busy     = div_busy;
  assign status_o.div_rem_zero = div_rem == '0;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_factor_o = out_factor_q;
  assign out_last_o   = out_last_q;

endmodule

// File: design/pf_ctrl.sv
// ----------------------------------------------------------------------------
// pf_ctrl: prime factorizer controller
// Sequences halving, trial division, the final prime and the last-flag flush.
// ----------------------------------------------------------------------------
module pf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pf_pkg::pf_status_t  status_i,
  output pf_pkg::pf_cmd_t     cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TWO   = 6'b000010,
    S_CHECK = 6'b000100,
    S_DIV   = 6'b001000,
    S_LAST  = 6'b010000,
    S_FLUSH = 6'b100000
  } pf_state_e;

  pf_state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.found_sel  = pf_pkg::FOUND_TWO;
    unique case (state_q)
      // Take a value; one without prime factors is dropped
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !status_i.value_lt2) begin
          cmd_o.load = 1'b1;
          state_d    = S_TWO;
        end
      end
      // Divide out every factor two
      S_TWO: begin
        if (status_i.rem_even) begin
          if (status_i.out_free) begin
            cmd_o.found     = 1'b1;
            cmd_o.found_sel = pf_pkg::FOUND_TWO;
            cmd_o.halve     = 1'b1;
          end
        end else begin
          state_d = S_CHECK;
        end
      end
      // Stop trial division once the divisor squared exceeds the rest
      S_CHECK: begin
        if (status_i.sq_gt_rem) begin
          state_d = S_LAST;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      // Divide again on a hit, else move to the next odd divisor
      S_DIV: begin
        if (!status_i.div_busy) begin
          if (status_i.div_rem_zero) begin
            if (status_i.out_free) begin
              cmd_o.found     = 1'b1;
              cmd_o.found_sel = pf_pkg::FOUND_TRIAL;
              cmd_o.take_quot = 1'b1;
              cmd_o.div_start = 1'b1;
            end
          end else begin
            cmd_o.step_trial = 1'b1;
            state_d          = S_CHECK;
          end
        end
      end
      // A rest above two is the largest prime
      S_LAST: begin
        if (!status_i.rem_gt2) begin
          state_d = S_FLUSH;
        end else if (status_i.out_free) begin
          cmd_o.found     = 1'b1;
          cmd_o.found_sel = pf_pkg::FOUND_REM;
          state_d         = S_FLUSH;
        end
      end
      // Emit the held factor marked as last
      S_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/prime_factorizer_core.sv
// ----------------------------------------------------------------------------
// prime_factorizer_core: trial-division prime factorization, one value at a time
// Steps: one halving per factor two, one run of the 31-step divider per odd trial divisor.
// One value per run, the next taken only back in idle; worst case about 23000 divisors.
// Reset: asynchronous, clears controller, valid flags and result count; no sweep.
// ----------------------------------------------------------------------------
module prime_factorizer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  pf_value_if.sink      in_i,
  pf_factor_if.source   out_o
);

  pf_pkg::pf_cmd_t     cmd;
  pf_pkg::pf_status_t  status;
  logic                in_ready;

  pf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .value_i      (in_i.value),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_factor_o (out_o.factor),
    .out_last_o   (out_o.last)
  );

  assign in_i.ready = in_ready;

`ifndef SYNTHESIS
  // A new value is taken only with the divider idle
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !status.div_busy)
    else $error("input ready while divider busy");

  // A started division is running on the next cycle
  a_div_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> status.div_busy)
    else $error("division start not taken");

  // Factors are pushed only into a free output register
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.found || cmd.flush) |-> status.out_free)
    else $error("factor pushed into a full output register");
`endif

endmodule
